FILE: rtl/mdfb_pkg.sv
`timescale 1ns / 1ps
// Shared constants and header lookup for the MAC data frame builder.
// No dependencies; imported by every module of the block.
package mdfb_pkg;

  localparam int unsigned MAX_PAYLOAD = 110;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned HDR_IDX_W   = 4;

  localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = 4'd14;
  localparam logic [HDR_IDX_W-1:0] HDR_FC0_IDX  = 4'd0;
  localparam logic [HDR_IDX_W-1:0] HDR_FC1_IDX  = 4'd1;
  localparam logic [HDR_IDX_W-1:0] HDR_SEQ_IDX  = 4'd2;
  localparam logic [HDR_IDX_W-1:0] HDR_SRC_IDX  = 4'd3;
  localparam logic [HDR_IDX_W-1:0] HDR_DST_IDX  = 4'd9;

  localparam logic [7:0] FRAME_CTRL_LO = 8'h41;
  localparam logic [7:0] FRAME_CTRL_HI = 8'h88;

  localparam logic [15:0] CRC_POLY = 16'h8408;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_PAYLOAD);

  localparam logic [7:0] ADDR_A [6] = '{8'hcd, 8'hab, 8'hff, 8'hff, 8'h40, 8'he8};
  localparam logic [7:0] ADDR_B [6] = '{8'h29, 8'h43, 8'hdc, 8'h1e, 8'hff, 8'hc8};

  // Role 0 sends address set B as source, role 1 sends set A as source.
  function automatic logic [7:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx,
                                          input logic role,
                                          input logic [7:0] seq);
    logic [HDR_IDX_W-1:0] src_k;
    logic [HDR_IDX_W-1:0] dst_k;
    logic [7:0]           res;
    src_k = idx - HDR_SRC_IDX;
    dst_k = idx - HDR_DST_IDX;
    res   = FRAME_CTRL_LO;
    if (idx == HDR_FC0_IDX) begin
      res = FRAME_CTRL_LO;
    end else if (idx == HDR_FC1_IDX) begin
      res = FRAME_CTRL_HI;
    end else if (idx == HDR_SEQ_IDX) begin
      res = seq;
    end else if (idx < HDR_DST_IDX) begin
      res = role ? ADDR_A[src_k[2:0]] : ADDR_B[src_k[2:0]];
    end else begin
      res = role ? ADDR_B[dst_k[2:0]] : ADDR_A[dst_k[2:0]];
    end
    return res;
  endfunction

endpackage

FILE: rtl/mac_data_frame_builder_unit.sv
`timescale 1ns / 1ps
// Top level of the MAC data frame builder: sequencer, output register and frame state.
// Depends on mdfb_pkg and mdfb_crc_unit.
//
// The block emits frame bytes through a single output register, and every header byte and
// every payload byte within the limit passes through one shared CRC unit as it is loaded
// into that register. It accepts a new payload byte only in its idle state, after the last
// one is done. The first payload byte of a frame is preceded by the 15 header bytes, and a
// last byte is followed by the two FCS bytes; a stalled output holds the sequence. Bytes
// beyond the payload limit are dropped and mark the frame as truncated.
module mac_data_frame_builder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_payload_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_frame_byte,
  output logic       out_frame_end,
  output logic       out_truncated,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);
  import mdfb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_DATA,
    ST_FCS_LO,
    ST_FCS_HI
  } state_t;

  state_t               state_r, state_nxt;
  logic                 role_r, role_nxt;
  logic                 hdr_role_r, hdr_role_nxt;
  logic [7:0]           seq_r, seq_nxt;
  logic [15:0]          crc_r, crc_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic                 inside_frame_r, inside_frame_nxt;
  logic                 overflow_r, overflow_nxt;
  logic [HDR_IDX_W-1:0] hdr_idx_r, hdr_idx_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic                 last_r, last_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic                 out_end_r, out_end_nxt;
  logic                 out_trunc_r, out_trunc_nxt;

  logic        slot_free;
  logic        in_xfer;
  logic [7:0]  crc_data;
  logic [15:0] crc_upd;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;

  assign crc_data = (state_r == ST_HDR) ? hdr_byte(hdr_idx_r, hdr_role_r, seq_r) : byte_r;

  mdfb_crc_unit u_crc (
    .crc_in  (crc_r),
    .data_in (crc_data),
    .crc_out (crc_upd)
  );

  always_comb begin
    state_nxt        = state_r;
    role_nxt         = cfg_wr_en ? cfg_wr_data : role_r;
    hdr_role_nxt     = hdr_role_r;
    seq_nxt          = seq_r;
    crc_nxt          = crc_r;
    count_nxt        = count_r;
    inside_frame_nxt = inside_frame_r;
    overflow_nxt     = overflow_r;
    hdr_idx_nxt      = hdr_idx_r;
    byte_nxt         = byte_r;
    last_nxt         = last_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_byte_nxt     = out_byte_r;
    out_end_nxt      = out_end_r;
    out_trunc_nxt    = out_trunc_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          byte_nxt = in_payload_byte;
          last_nxt = in_last_byte;
          if (!inside_frame_r) begin
            crc_nxt          = '0;
            count_nxt        = '0;
            overflow_nxt     = 1'b0;
            inside_frame_nxt = 1'b1;
            hdr_role_nxt     = role_r;
            hdr_idx_nxt      = HDR_FC0_IDX;
            state_nxt        = ST_HDR;
          end else begin
            state_nxt = ST_DATA;
          end
        end
      end
      ST_HDR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = crc_data;
          out_end_nxt   = 1'b0;
          out_trunc_nxt = 1'b0;
          crc_nxt       = crc_upd;
          hdr_idx_nxt   = hdr_idx_r + 1'b1;
          if (hdr_idx_r == HDR_SEQ_IDX) begin
            seq_nxt = seq_r + 1'b1;
          end
          if (hdr_idx_r == HDR_LAST_IDX) begin
            state_nxt = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (count_r < MAX_COUNT) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = byte_r;
            out_end_nxt   = 1'b0;
            out_trunc_nxt = 1'b0;
            crc_nxt       = crc_upd;
            count_nxt     = count_r + 1'b1;
            state_nxt     = last_r ? ST_FCS_LO : ST_IDLE;
          end
        end else begin
          overflow_nxt = 1'b1;
          state_nxt    = last_r ? ST_FCS_LO : ST_IDLE;
        end
      end
      ST_FCS_LO: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = crc_r[7:0];
          out_end_nxt   = 1'b0;
          out_trunc_nxt = overflow_r;
          state_nxt     = ST_FCS_HI;
        end
      end
      ST_FCS_HI: begin
        if (slot_free) begin
          out_valid_nxt    = 1'b1;
          out_byte_nxt     = crc_r[15:8];
          out_end_nxt      = 1'b1;
          out_trunc_nxt    = overflow_r;
          crc_nxt          = '0;
          count_nxt        = '0;
          overflow_nxt     = 1'b0;
          inside_frame_nxt = 1'b0;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      role_r         <= 1'b0;
      seq_r          <= '0;
      crc_r          <= '0;
      count_r        <= '0;
      inside_frame_r <= 1'b0;
      overflow_r     <= 1'b0;
      hdr_idx_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      role_r         <= role_nxt;
      seq_r          <= seq_nxt;
      crc_r          <= crc_nxt;
      count_r        <= count_nxt;
      inside_frame_r <= inside_frame_nxt;
      overflow_r     <= overflow_nxt;
      hdr_idx_r      <= hdr_idx_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    hdr_role_r  <= hdr_role_nxt;
    byte_r      <= byte_nxt;
    last_r      <= last_nxt;
    out_byte_r  <= out_byte_nxt;
    out_end_r   <= out_end_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_frame_end  = out_end_r;
  assign out_truncated  = out_trunc_r;

`ifndef ASSERT_OFF
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_COUNT)
    else $error("payload count exceeds the limit");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |-> count_r == MAX_COUNT)
    else $error("overflow flagged before the payload limit was reached");

  a_hdr_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HDR) |-> inside_frame_r)
    else $error("header emitted outside a frame");

  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !inside_frame_r) |=> (state_r == ST_HDR) && (hdr_idx_r == HDR_FC0_IDX))
    else $error("first transfer of a frame did not start the header");
`endif

endmodule

FILE: rtl/mdfb_crc_unit.sv
`timescale 1ns / 1ps
// Byte-wide update of the reflected CRC-16 (polynomial 0x8408) shared by the header and payload bytes.
// Depends on mdfb_pkg.
module mdfb_crc_unit (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);
  import mdfb_pkg::*;

  always_comb begin
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb = data_in[k] ^ c[0];
      c  = {1'b0, c[15:1]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    crc_out = c;
  end

endmodule
